[sv/button_debounce_long_press_repeat_defines.svh]
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat_defines
// assertion macros shared by the button debounce block
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BDLPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bdlpr assertion failed");

// next-cycle implication, disabled during reset
`define BDLPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bdlpr assertion failed");

`endif

[sv/bdlpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdlpr_pkg
// shared widths, register map, phase codes and reset values
// ----------------------------------------------------------------------------
package bdlpr_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int THRESH_W            = 16;
    localparam int IN_TDATA_W          = 8;
    localparam int OUT_TDATA_W         = 8;
    localparam int APB_ADDR_W          = 4;
    localparam int APB_DATA_W          = 32;

    // register indexes
    localparam logic [1:0] REG_HOLD_MODE   = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE    = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS  = 2'd2;
    localparam logic [1:0] REG_REPEAT      = 2'd3;

    // phase codes
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_DEBOUNCE = 2'd1;
    localparam logic [1:0] PH_LONG     = 2'd2;
    localparam logic [1:0] PH_RELEASE  = 2'd3;

    // register reset values
    localparam logic                HOLD_MODE_RST  = 1'b1;
    localparam logic [THRESH_W-1:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [THRESH_W-1:0] LONG_PRESS_RST = 16'd3000;
    localparam logic [THRESH_W-1:0] REPEAT_RST     = 16'd100;

    typedef struct packed {
        logic [1:0] phase;
        logic       repeat_event;
        logic       press_event;
    } result_t;

endpackage

[sv/button_debounce_long_press_repeat.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat
// debounced push button with optional long-press auto-repeat
// ----------------------------------------------------------------------------
// Usage: feed one request per millisecond tick on the s_ channel, carrying
// the sampled active-low pin in s_tdata[0]. Every request yields exactly one
// result on the m_ channel: press_event, repeat_event and the phase reached
// after that tick. The phase machine and the saturating tick counter update
// in the same cycle a request is accepted.
// The result is registered; m_tvalid rises the cycle after input acceptance.
// Throughput: one request every cycle while m_tready is high; the next-state
// logic is a single increment and three compares between the input handshake
// and the result register.
// Stall: the result register holds while m_tready is low; s_tready follows
// as (!m_tvalid || m_tready), so a new request is taken in the same cycle
// the pending result leaves.
// Reset (aresetn low, synchronous): phase idle, counter zero, no result
// pending, registers back to hold mode on, 30 / 3000 / 100 ticks. The user
// writes thresholds over the APB port only while the block is idle; unenforced.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_repeat_defines.svh"

module button_debounce_long_press_repeat
    import bdlpr_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input channel
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] pin_level, [7:1] zero
    // result channel
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] press_event, [1] repeat_event,
                                              // [3:2] phase, [7:4] zero
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

    // configuration registers
    logic                hold_mode_reg;
    logic [THRESH_W-1:0] debounce_reg;
    logic [THRESH_W-1:0] long_press_reg;
    logic [THRESH_W-1:0] repeat_reg;

    // state
    logic [1:0]             phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] elapsed_reg, elapsed_next;
    logic [COUNT_WIDTH-1:0] elapsed_inc;

    // result register
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t res_next;

    logic       in_accept;
    logic       pressed;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic       over_debounce, over_long, over_repeat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_mode_reg  <= HOLD_MODE_RST;
            debounce_reg   <= DEBOUNCE_RST;
            long_press_reg <= LONG_PRESS_RST;
            repeat_reg     <= REPEAT_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_HOLD_MODE:  hold_mode_reg  <= pwdata[0];
                REG_DEBOUNCE:   debounce_reg   <= pwdata[THRESH_W-1:0];
                REG_LONG_PRESS: long_press_reg <= pwdata[THRESH_W-1:0];
                REG_REPEAT:     repeat_reg     <= pwdata[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_HOLD_MODE:  prdata = APB_DATA_W'(hold_mode_reg);
            REG_DEBOUNCE:   prdata = APB_DATA_W'(debounce_reg);
            REG_LONG_PRESS: prdata = APB_DATA_W'(long_press_reg);
            REG_REPEAT:     prdata = APB_DATA_W'(repeat_reg);
            default:        prdata = '0;
        endcase
    end

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign pressed   = !s_tdata[0];

    // saturating tick count, frozen while idle
    assign elapsed_inc = ((phase_reg != PH_IDLE) && (elapsed_reg != '1))
                       ? elapsed_reg + COUNT_WIDTH'(1) : elapsed_reg;

    assign over_debounce = CMP_W'(elapsed_inc) > CMP_W'(debounce_reg);
    assign over_long     = CMP_W'(elapsed_inc) > CMP_W'(long_press_reg);
    assign over_repeat   = CMP_W'(elapsed_inc) > CMP_W'(repeat_reg);

    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_inc;
        res_next     = '0;
        case (phase_reg)
            PH_IDLE: begin
                if (pressed) begin
                    elapsed_next = '0;
                    phase_next   = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (over_debounce) begin
                    res_next.press_event = 1'b1;
                    elapsed_next         = '0;
                    phase_next           = hold_mode_reg ? PH_LONG : PH_RELEASE;
                end
            end
            PH_LONG: begin
                if (pressed && over_long) begin
                    elapsed_next = '0;
                    phase_next   = PH_RELEASE;
                end else if (!pressed) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                if (!pressed) begin
                    phase_next = PH_IDLE;
                end else if (hold_mode_reg && over_repeat) begin
                    res_next.repeat_event = 1'b1;
                    elapsed_next          = '0;
                end
            end
        endcase
        res_next.phase = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
            end
            if (in_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_data_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    // press event only on leaving debounce
    `BDLPR_ASSERT_NOW(a_press_phase, aclk, aresetn,
        out_valid_reg && out_data_reg.press_event,
        out_data_reg.phase == PH_LONG || out_data_reg.phase == PH_RELEASE)

    // repeat event only while held in awaiting release
    `BDLPR_ASSERT_NOW(a_repeat_phase, aclk, aresetn,
        out_valid_reg && out_data_reg.repeat_event,
        out_data_reg.phase == PH_RELEASE && !out_data_reg.press_event)

    // released pin in idle stays idle with no events
    `BDLPR_ASSERT_NEXT(a_idle_hold, aclk, aresetn,
        in_accept && phase_reg == PH_IDLE && s_tdata[0],
        m_tvalid && m_tdata[3:0] == 4'b0000 && phase_reg == PH_IDLE)

endmodule

[verif/button_debounce_long_press_repeat_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_repeat_tb
// self-checking bench for the debounced button with long-press auto-repeat
// ----------------------------------------------------------------------------
// Pin-level ticks go in on the s_ channel; every tick is run through a local
// model of the phase machine and its saturating counter, and each result on
// the m_ channel is compared field by field with the oldest prediction.
// A short table covers press, hold, repeat, release and mode changes during a
// press, then random press and release bursts run under a series of threshold
// settings, one of them with both channels kept busy every cycle. Both
// channels idle and stall at random; registers are written over APB while
// nothing is in flight and read back.
// ----------------------------------------------------------------------------
module button_debounce_long_press_repeat_tb;
    import bdlpr_pkg::*;

    localparam int COUNT_W     = COUNT_WIDTH_DEFAULT;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 38;
    localparam int PHASE_TICKS = 125;
    localparam int NUM_PHASES  = 10;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e     kind;
        logic [1:0]    reg_idx;
        logic [15:0]   reg_value;
        logic          pin;
        logic          typed;
        result_t       res;
    } row_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [0] pin_level, [7:1] zero
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [0] press_event, [1] repeat_event,
                                             // [3:2] phase, [7:4] zero
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [APB_DATA_W-1:0]  pwdata   = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // local copy of the button state and thresholds
    logic                   hold_cfg     = HOLD_MODE_RST;
    logic [THRESH_W-1:0]    debounce_cfg = DEBOUNCE_RST;
    logic [THRESH_W-1:0]    long_cfg     = LONG_PRESS_RST;
    logic [THRESH_W-1:0]    repeat_cfg   = REPEAT_RST;
    logic [1:0]             btn_phase    = PH_IDLE;
    logic [COUNT_W-1:0]     tick_count   = '0;

    result_t                expected_q[$];
    int                     errors       = 0;
    int                     ticks_sent   = 0;
    int                     quiet_cycles = 0;
    bit                     steady       = 1'b0;

    row_t directed_rows [26] = '{
        '{ROW_WRITE, REG_DEBOUNCE,   16'd0, 1'b1, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_WRITE, REG_LONG_PRESS, 16'd1, 1'b1, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_WRITE, REG_REPEAT,     16'd0, 1'b1, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b1, 1'b1, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b1, '{PH_DEBOUNCE, 1'b0, 1'b0}},
        // pin is not looked at when the debounce time runs out
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b1, 1'b1, '{PH_LONG,     1'b0, 1'b1}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        // repeat stops when hold mode drops during a press
        '{ROW_WRITE, REG_HOLD_MODE,  16'd0, 1'b1, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b1, 1'b1, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b1, '{PH_DEBOUNCE, 1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_WRITE, REG_HOLD_MODE,  16'd1, 1'b1, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b1, 1'b1, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b1, '{PH_DEBOUNCE, 1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        // release after the press with hold mode off, which skips the long-press wait
        '{ROW_WRITE, REG_HOLD_MODE,  16'd0, 1'b1, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b1, 1'b1, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b1, '{PH_DEBOUNCE, 1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b0, 1'b0, '{PH_IDLE,     1'b0, 1'b0}},
        '{ROW_TICK,  REG_HOLD_MODE,  16'd0, 1'b1, 1'b1, '{PH_IDLE,     1'b0, 1'b0}}
    };

    button_debounce_long_press_repeat DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    function automatic result_t predict_tick(input logic pin);
        result_t r;
        logic    pressed;
        pressed = (pin == 1'b0);
        r = '0;
        if (btn_phase != PH_IDLE && tick_count != '1) tick_count = tick_count + 1'b1;
        case (btn_phase)
            PH_IDLE: begin
                if (pressed) begin
                    tick_count = '0;
                    btn_phase  = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE: begin
                if (tick_count > debounce_cfg) begin
                    r.press_event = 1'b1;
                    tick_count    = '0;
                    btn_phase     = hold_cfg ? PH_LONG : PH_RELEASE;
                end
            end
            PH_LONG: begin
                if (pressed && tick_count > long_cfg) begin
                    tick_count = '0;
                    btn_phase  = PH_RELEASE;
                end else if (!pressed) begin
                    btn_phase = PH_IDLE;
                end
            end
            default: begin
                if (!pressed) begin
                    btn_phase = PH_IDLE;
                end else if (hold_cfg && tick_count > repeat_cfg) begin
                    r.repeat_event = 1'b1;
                    tick_count     = '0;
                end
            end
        endcase
        r.phase = btn_phase;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    // result channel: random stalls and comparison with the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (aresetn) begin
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("result %0h arrived with no request outstanding", m_tdata);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    got  = result_t'(m_tdata[3:0]);
                    check_field("press_event", 32'(want.press_event), 32'(got.press_event));
                    check_field("repeat_event", 32'(want.repeat_event), 32'(got.repeat_event));
                    check_field("phase", 32'(want.phase), 32'(got.phase));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL button_debounce_long_press_repeat");
            $finish;
        end
    end

    task automatic send_tick(input logic pin, input logic use_typed = 1'b0,
                             input result_t typed_res = '0);
        result_t want;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        want = predict_tick(pin);
        if (use_typed) want = typed_res;
        expected_q.push_back(want);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-1){1'b0}}, pin};
        do @(posedge aclk); while (!s_tready);
        ticks_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic reg_readback(input logic [1:0] idx);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        case (idx)
            REG_HOLD_MODE:  check_field("hold_mode", 32'(hold_cfg), rd & 32'h1);
            REG_DEBOUNCE:   check_field("debounce_ticks", 32'(debounce_cfg), rd & 32'hFFFF);
            REG_LONG_PRESS: check_field("long_press_ticks", 32'(long_cfg), rd & 32'hFFFF);
            default:        check_field("repeat_ticks", 32'(repeat_cfg), rd & 32'hFFFF);
        endcase
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [15:0] value);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, idx, APB_DATA_W'(value), rd);
        case (idx)
            REG_HOLD_MODE:  hold_cfg     = value[0];
            REG_DEBOUNCE:   debounce_cfg = value;
            REG_LONG_PRESS: long_cfg     = value;
            default:        repeat_cfg   = value;
        endcase
        reg_readback(idx);
    endtask

    initial begin
        int start;
        int span;
        int press_len;
        int deb;
        int lng;
        int rpt;
        logic hold;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        reg_readback(REG_HOLD_MODE);
        reg_readback(REG_DEBOUNCE);
        reg_readback(REG_LONG_PRESS);
        reg_readback(REG_REPEAT);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                drain();
                reg_write(directed_rows[i].reg_idx, directed_rows[i].reg_value);
            end else begin
                send_tick(directed_rows[i].pin, directed_rows[i].typed,
                          directed_rows[i].res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin hold = 1'b1; deb = 0; lng = 0; rpt = 0; end
                1: begin hold = 1'b1; deb = 0; lng = 16'hFFFF; rpt = 16'hFFFF; end
                2: begin hold = 1'b1; deb = $urandom_range(0, 3); lng = 0; rpt = 16'hFFFF; end
                3: begin
                    hold = 1'($urandom_range(0, 1));
                    deb  = $urandom_range(0, 16'hFFFF);
                    lng  = $urandom_range(0, 16'hFFFF);
                    rpt  = $urandom_range(0, 16'hFFFF);
                end
                4: begin hold = 1'b0; deb = 16'hFFFF; lng = 16'hFFFF; rpt = 16'hFFFF; end
                default: begin
                    hold = 1'($urandom_range(0, 1));
                    deb  = $urandom_range(0, 6);
                    lng  = $urandom_range(0, 12);
                    rpt  = $urandom_range(0, 5);
                end
            endcase
            drain();
            reg_write(REG_HOLD_MODE, 16'(hold));
            reg_write(REG_DEBOUNCE, 16'(deb));
            reg_write(REG_LONG_PRESS, 16'(lng));
            reg_write(REG_REPEAT, 16'(rpt));
            // one stretch with both channels busy every cycle
            steady = (p == 5);
            span = deb + lng + 3 * rpt + 8;
            if (span > 40) span = 40;
            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) begin
                if ($urandom_range(0, 99) < 85) begin
                    press_len = $urandom_range(1, span);
                    repeat (press_len) send_tick(1'b0);
                    repeat ($urandom_range(1, 6)) send_tick(1'b1);
                end else begin
                    // bounce noise
                    repeat ($urandom_range(1, 5)) send_tick(1'($urandom_range(0, 1)));
                end
                if ($urandom_range(0, 29) == 0) drain();
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (errors == 0 && expected_q.size() == 0)
            $display("PASS button_debounce_long_press_repeat");
        else
            $display("FAIL button_debounce_long_press_repeat");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/bdlpr_pkg.sv
sv/button_debounce_long_press_repeat.sv
verif/button_debounce_long_press_repeat_tb.sv
